// ----- rtl/cell_voltage_pack_monitor_defines.svh -----
// ----------------------------------------------------------------------------
// cell voltage pack monitor assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CELL_VOLTAGE_PACK_MONITOR_DEFINES_SVH
`define CELL_VOLTAGE_PACK_MONITOR_DEFINES_SVH

// same-cycle implication
`define CVPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cvpm same-cycle check failed");

// next-cycle implication
`define CVPM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cvpm next-cycle check failed");

`endif

// ----- rtl/cvpm_pkg.sv -----
// ----------------------------------------------------------------------------
// cvpm_pkg
// types and fixed constants of the cell voltage pack monitor
// ----------------------------------------------------------------------------
package cvpm_pkg;

   localparam int VOLT_W    = 16;
   localparam int SUM_W     = 23;
   localparam int IDX_W     = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [VOLT_W-1:0] VOLT_FULL = 16'hFFFF;
   localparam logic [SUM_W-1:0]  SUM_FULL  = 23'h7FFFFF;

   localparam logic [VOLT_W-1:0] OV_LIMIT_RST = 16'd42000;
   localparam logic [VOLT_W-1:0] UV_LIMIT_RST = 16'd28000;
   localparam logic [VOLT_W-1:0] LV_WARN_RST  = 16'd30000;

   localparam logic [CSR_IDX_W-1:0] CSR_OV_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LV_WARN  = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SWEEP = 5'b00010,
      S_MULT  = 5'b00100,
      S_DIV   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

endpackage

// ----- rtl/cvpm_ram.sv -----
// ----------------------------------------------------------------------------
// cvpm_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cvpm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cell_voltage_pack_monitor.sv -----
// ----------------------------------------------------------------------------
// cell_voltage_pack_monitor
// stores per-board cell voltage reports and returns pack figures and flags
// ----------------------------------------------------------------------------
// usage
//   request: a board report is taken on a clock edge with start high and
//   busy low. the report goes into one ram row of {min, max, avg}; an index
//   at or above BOARDS writes nothing but still gives a result.
//   response: rsp_valid pulses for one cycle with the pack figures; the
//   receiver cannot hold it off, so results are never stalled.
//   csr: csr_ready is always high; a transfer writes register csr_index,
//   and index 3 writes nothing. write limits only while busy is low.
// timing
//   after the accepting edge the ram is swept one row per cycle, the sum
//   is scaled by the cell count, then average and sum are divided by
//   BOARDS through reciprocal multiplies, and the result shows for 1 cycle.
//   a new report is taken only once busy is low again after the result.
// reset
//   clears limits to their defaults and all row valid bits; a row not
//   yet written reads as min full scale, max and avg zero.
// ----------------------------------------------------------------------------
module cell_voltage_pack_monitor #(
   parameter int BOARDS        = 8,
   parameter int CELLS_IN_PACK = 108,
   parameter int VOLT_BITS     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cvpm_pkg::IDX_W-1:0]          req_board_index,
   input  logic [cvpm_pkg::VOLT_W-1:0]         req_board_min_voltage,
   input  logic [cvpm_pkg::VOLT_W-1:0]         req_board_max_voltage,
   input  logic [cvpm_pkg::VOLT_W-1:0]         req_board_avg_voltage,
   output logic                                rsp_valid,
   output logic [cvpm_pkg::VOLT_W-1:0]         rsp_pack_max_voltage,
   output logic [cvpm_pkg::VOLT_W-1:0]         rsp_pack_min_voltage,
   output logic [cvpm_pkg::VOLT_W-1:0]         rsp_pack_avg_voltage,
   output logic [cvpm_pkg::SUM_W-1:0]          rsp_pack_sum_voltage,
   output logic                                rsp_over_voltage,
   output logic                                rsp_under_voltage,
   output logic                                rsp_low_voltage,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cvpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cvpm_pkg::VOLT_W-1:0]         csr_wdata
);

   import cvpm_pkg::*;

   localparam int SW   = (VOLT_BITS < VOLT_W) ? VOLT_BITS : VOLT_W;
   localparam int BAW  = (BOARDS > 1) ? $clog2(BOARDS) : 1;
   localparam int CNW  = $clog2(BOARDS + 1);
   localparam int LB   = $clog2(BOARDS);
   localparam int TW   = SW + LB;
   localparam int CW   = $clog2(CELLS_IN_PACK + 1);
   localparam int PW   = TW + CW;
   localparam int AS   = TW + LB;
   localparam int SS   = PW + LB;
   localparam int XW   = (PW > SUM_W) ? PW : SUM_W;
   localparam int MW   = 3 * SW;

   // rounded-up reciprocals of BOARDS, exact for every numerator in range
   localparam logic [TW:0] A_RECIP =
      (TW+1)'(((64'd1 << AS) + 64'(BOARDS) - 64'd1) / 64'(BOARDS));
   localparam logic [PW:0] S_RECIP =
      (PW+1)'(((64'd1 << SS) + 64'(BOARDS) - 64'd1) / 64'(BOARDS));

   state_type        state_ff, state_in;
   logic [BOARDS-1:0] vld_ff, vld_in;
   logic [CNW-1:0]   rd_cnt_ff, rd_cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [VOLT_W-1:0] pmax_ff, pmax_in;
   logic [VOLT_W-1:0] pmin_ff, pmin_in;
   logic [TW-1:0]    total_ff, total_in;
   logic [PW-1:0]    num_s_ff, num_s_in;
   logic [PW-1:0]    num_a_ff, num_a_in;
   logic [VOLT_W-1:0] ov_ff, ov_in;
   logic [VOLT_W-1:0] uv_ff, uv_in;
   logic [VOLT_W-1:0] lv_ff, lv_in;

   logic             accept;
   logic             idx_ok;
   logic             wr_en;
   logic [BAW-1:0]   wr_addr;
   logic [MW-1:0]    wr_data;
   logic             rd_en;
   logic [BAW-1:0]   rd_addr;
   logic [MW-1:0]    rd_data;
   logic [SW-1:0]    e_min, e_max, e_avg;
   logic [2*TW:0]    a_prod;
   logic [2*PW:0]    s_prod;
   logic [XW-1:0]    q_avg, q_sum;

   assign accept    = start && !busy;
   assign idx_ok    = 32'(req_board_index) < 32'(BOARDS);
   assign wr_en     = accept && idx_ok;
   assign wr_addr   = BAW'(req_board_index);
   assign wr_data   = {SW'(req_board_min_voltage), SW'(req_board_max_voltage),
                       SW'(req_board_avg_voltage)};
   assign rd_en     = (state_ff == S_SWEEP) && (rd_cnt_ff < CNW'(BOARDS));
   assign rd_addr   = rd_cnt_ff[BAW-1:0];
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   cvpm_ram #(
      .WIDTH (MW),
      .DEPTH (BOARDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rows never written read as their reset values
   assign e_min = rd_vld_ff ? rd_data[3*SW-1:2*SW] : {SW{1'b1}};
   assign e_max = rd_vld_ff ? rd_data[2*SW-1:SW]   : '0;
   assign e_avg = rd_vld_ff ? rd_data[SW-1:0]      : '0;

   // divide by BOARDS as multiply by reciprocal and shift
   assign a_prod = (2*TW+1)'(num_a_ff[TW-1:0]) * (2*TW+1)'(A_RECIP);
   assign s_prod = (2*PW+1)'(num_s_ff) * (2*PW+1)'(S_RECIP);

   always_comb begin
      state_in   = state_ff;
      vld_in     = vld_ff;
      rd_cnt_in  = rd_cnt_ff;
      rd_pend_in = rd_en;
      rd_vld_in  = vld_ff[rd_addr];
      pmax_in    = pmax_ff;
      pmin_in    = pmin_ff;
      total_in   = total_ff;
      num_s_in   = num_s_ff;
      num_a_in   = num_a_ff;
      ov_in      = ov_ff;
      uv_in      = uv_ff;
      lv_in      = lv_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OV_LIMIT: ov_in = csr_wdata;
            CSR_UV_LIMIT: uv_in = csr_wdata;
            CSR_LV_WARN:  lv_in = csr_wdata;
            default: ;
         endcase
      end

      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_SWEEP;
               rd_cnt_in = '0;
               pmax_in   = '0;
               pmin_in   = ov_ff;
               total_in  = '0;
            end
         end
         S_SWEEP: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + CNW'(1);
            end
            if (rd_pend_ff) begin
               if (VOLT_W'(e_max) > pmax_ff) begin
                  pmax_in = VOLT_W'(e_max);
               end
               if (VOLT_W'(e_min) < pmin_ff) begin
                  pmin_in = VOLT_W'(e_min);
               end
               total_in = total_ff + TW'(e_avg);
               if (rd_cnt_ff == CNW'(BOARDS)) begin
                  state_in = S_MULT;
               end
            end
         end
         S_MULT: begin
            num_s_in = PW'(total_ff) * PW'(CELLS_IN_PACK);
            num_a_in = PW'(total_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            num_s_in = PW'(s_prod >> SS);
            num_a_in = PW'(a_prod >> AS);
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         vld_ff     <= '0;
         rd_pend_ff <= 1'b0;
         ov_ff      <= OV_LIMIT_RST;
         uv_ff      <= UV_LIMIT_RST;
         lv_ff      <= LV_WARN_RST;
      end else begin
         state_ff   <= state_in;
         vld_ff     <= vld_in;
         rd_pend_ff <= rd_pend_in;
         ov_ff      <= ov_in;
         uv_ff      <= uv_in;
         lv_ff      <= lv_in;
      end
      rd_cnt_ff <= rd_cnt_in;
      rd_vld_ff <= rd_vld_in;
      pmax_ff   <= pmax_in;
      pmin_ff   <= pmin_in;
      total_ff  <= total_in;
      num_s_ff  <= num_s_in;
      num_a_ff  <= num_a_in;
   end

   assign q_avg = XW'(num_a_ff);
   assign q_sum = XW'(num_s_ff);

   assign rsp_valid            = (state_ff == S_OUT);
   assign rsp_pack_max_voltage = pmax_ff;
   assign rsp_pack_min_voltage = pmin_ff;
   assign rsp_pack_avg_voltage = (q_avg > XW'(VOLT_FULL)) ? VOLT_FULL : q_avg[VOLT_W-1:0];
   assign rsp_pack_sum_voltage = (q_sum > XW'(SUM_FULL)) ? SUM_FULL : q_sum[SUM_W-1:0];
   assign rsp_over_voltage     = pmax_ff > ov_ff;
   assign rsp_under_voltage    = pmin_ff < uv_ff;
   assign rsp_low_voltage      = pmin_ff < lv_ff;

endmodule

// ----- rtl/cvpm_checker.sv -----
// ----------------------------------------------------------------------------
// cvpm_checker
// port-level checks of the cell voltage pack monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "cell_voltage_pack_monitor_defines.svh"

module cvpm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [cvpm_pkg::VOLT_W-1:0] rsp_pack_max_voltage,
   input logic                        rsp_over_voltage
);

   `CVPM_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CVPM_ASSERT_IMP(a_rsp_in_flight, clock, reset, rsp_valid, busy)
   `CVPM_ASSERT_NXT(a_rsp_ends_item, clock, reset, rsp_valid, !rsp_valid && !busy)
   `CVPM_ASSERT_IMP(a_over_nonzero, clock, reset, rsp_valid && rsp_over_voltage, rsp_pack_max_voltage != '0)

endmodule

bind cell_voltage_pack_monitor cvpm_checker u_checker (.*);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the cell voltage pack monitor against a mirrored copy of its board
// tables and limits: every report taken is folded into the mirror, and each
// pack result strobe is compared against the oldest predicted result. a
// directed set and a first batch run under the reset limits, then five
// limit settings each run a batch of mostly plausible board reports plus
// noise, under changing sender idle rates
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BOARDS        = 8;
   localparam int CELLS_IN_PACK = 108;
   localparam int SETTLE_CYCLES = 25;
   localparam int PHASE_REPORTS = 270;
   localparam int SHOWN_ERRORS  = 10;

   localparam logic [cvpm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [cvpm_pkg::IDX_W-1:0]  idx;
      logic [cvpm_pkg::VOLT_W-1:0] min_v;
      logic [cvpm_pkg::VOLT_W-1:0] max_v;
      logic [cvpm_pkg::VOLT_W-1:0] avg_v;
   } board_report_type;

   typedef struct packed {
      logic [cvpm_pkg::VOLT_W-1:0] max_v;
      logic [cvpm_pkg::VOLT_W-1:0] min_v;
      logic [cvpm_pkg::VOLT_W-1:0] avg_v;
      logic [cvpm_pkg::SUM_W-1:0]  sum_v;
      logic                        over_v;
      logic                        under_v;
      logic                        low_v;
   } pack_result_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [cvpm_pkg::IDX_W-1:0]        req_board_index = '0;
   logic [cvpm_pkg::VOLT_W-1:0]       req_board_min_voltage = '0;
   logic [cvpm_pkg::VOLT_W-1:0]       req_board_max_voltage = '0;
   logic [cvpm_pkg::VOLT_W-1:0]       req_board_avg_voltage = '0;
   logic                              rsp_valid;
   logic [cvpm_pkg::VOLT_W-1:0]       rsp_pack_max_voltage;
   logic [cvpm_pkg::VOLT_W-1:0]       rsp_pack_min_voltage;
   logic [cvpm_pkg::VOLT_W-1:0]       rsp_pack_avg_voltage;
   logic [cvpm_pkg::SUM_W-1:0]        rsp_pack_sum_voltage;
   logic                              rsp_over_voltage;
   logic                              rsp_under_voltage;
   logic                              rsp_low_voltage;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [cvpm_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [cvpm_pkg::VOLT_W-1:0]       csr_wdata = '0;

   logic [cvpm_pkg::VOLT_W-1:0] ov_limit_mirror;
   logic [cvpm_pkg::VOLT_W-1:0] uv_limit_mirror;
   logic [cvpm_pkg::VOLT_W-1:0] lv_warn_mirror;
   logic [cvpm_pkg::VOLT_W-1:0] board_min_mirror [BOARDS];
   logic [cvpm_pkg::VOLT_W-1:0] board_max_mirror [BOARDS];
   logic [cvpm_pkg::VOLT_W-1:0] board_avg_mirror [BOARDS];

   board_report_type reports_pending [$];
   pack_result_type  pack_results_due [$];

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   sender_idle_pct = 20;
   int   reports_queued = 0;
   int   reports_taken = 0;
   int   packs_checked = 0;
   int   limit_writes = 0;
   int   errors = 0;

   cell_voltage_pack_monitor i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_board_index       (req_board_index),
      .req_board_min_voltage (req_board_min_voltage),
      .req_board_max_voltage (req_board_max_voltage),
      .req_board_avg_voltage (req_board_avg_voltage),
      .rsp_valid             (rsp_valid),
      .rsp_pack_max_voltage  (rsp_pack_max_voltage),
      .rsp_pack_min_voltage  (rsp_pack_min_voltage),
      .rsp_pack_avg_voltage  (rsp_pack_avg_voltage),
      .rsp_pack_sum_voltage  (rsp_pack_sum_voltage),
      .rsp_over_voltage      (rsp_over_voltage),
      .rsp_under_voltage     (rsp_under_voltage),
      .rsp_low_voltage       (rsp_low_voltage),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // store one report in the mirror tables and fold them into pack figures
   function automatic pack_result_type pack_figures(board_report_type r);
      pack_result_type f;
      logic [19:0]  total;
      logic [31:0]  scaled;
      board_min_mirror[r.idx] = r.min_v;
      board_max_mirror[r.idx] = r.max_v;
      board_avg_mirror[r.idx] = r.avg_v;
      f.max_v = '0;
      f.min_v = ov_limit_mirror;
      total = '0;
      for (int b = 0; b < BOARDS; b++) begin
         if (board_max_mirror[b] > f.max_v) begin
            f.max_v = board_max_mirror[b];
         end
         if (board_min_mirror[b] < f.min_v) begin
            f.min_v = board_min_mirror[b];
         end
         total = total + 20'(board_avg_mirror[b]);
      end
      scaled = 32'(total) / BOARDS;
      f.avg_v = (scaled > 32'hFFFF) ? cvpm_pkg::VOLT_FULL : scaled[cvpm_pkg::VOLT_W-1:0];
      scaled = 32'(total) * CELLS_IN_PACK / BOARDS;
      f.sum_v = (scaled > 32'h7FFFFF) ? cvpm_pkg::SUM_FULL : scaled[cvpm_pkg::SUM_W-1:0];
      f.over_v = f.max_v > ov_limit_mirror;
      f.under_v = f.min_v < uv_limit_mirror;
      f.low_v = f.min_v < lv_warn_mirror;
      return f;
   endfunction

   always @(posedge clock) begin : watch_ports
      pack_result_type seen;
      pack_result_type due;
      req_taken <= start && !busy && !reset;
      csr_taken <= csr_valid && csr_ready;
      if (reset) begin
         ov_limit_mirror = cvpm_pkg::OV_LIMIT_RST;
         uv_limit_mirror = cvpm_pkg::UV_LIMIT_RST;
         lv_warn_mirror = cvpm_pkg::LV_WARN_RST;
         for (int b = 0; b < BOARDS; b++) begin
            board_min_mirror[b] = cvpm_pkg::VOLT_FULL;
            board_max_mirror[b] = '0;
            board_avg_mirror[b] = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            limit_writes++;
            case (csr_index)
               cvpm_pkg::CSR_OV_LIMIT: ov_limit_mirror = csr_wdata;
               cvpm_pkg::CSR_UV_LIMIT: uv_limit_mirror = csr_wdata;
               cvpm_pkg::CSR_LV_WARN:  lv_warn_mirror = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            pack_results_due.push_back(pack_figures({req_board_index, req_board_min_voltage,
               req_board_max_voltage, req_board_avg_voltage}));
            reports_taken++;
         end
         if (rsp_valid) begin
            seen = {rsp_pack_max_voltage, rsp_pack_min_voltage, rsp_pack_avg_voltage,
               rsp_pack_sum_voltage, rsp_over_voltage, rsp_under_voltage, rsp_low_voltage};
            if (pack_results_due.size() == 0) begin
               errors++;
               if (errors <= SHOWN_ERRORS) begin
                  $display("%0t: pack result with none pending: max %0d min %0d avg %0d sum %0d",
                     $realtime, seen.max_v, seen.min_v, seen.avg_v, seen.sum_v);
               end
            end else begin
               due = pack_results_due.pop_front();
               packs_checked++;
               if (seen.max_v !== due.max_v || seen.min_v !== due.min_v ||
                   seen.avg_v !== due.avg_v || seen.sum_v !== due.sum_v ||
                   seen.over_v !== due.over_v || seen.under_v !== due.under_v ||
                   seen.low_v !== due.low_v) begin
                  errors++;
                  if (errors <= SHOWN_ERRORS) begin
                     $display("%0t: pack mismatch exp max %0d min %0d avg %0d sum %0d ov %b uv %b lv %b",
                        $realtime, due.max_v, due.min_v, due.avg_v, due.sum_v,
                        due.over_v, due.under_v, due.low_v);
                     $display("%0t:               got max %0d min %0d avg %0d sum %0d ov %b uv %b lv %b",
                        $realtime, seen.max_v, seen.min_v, seen.avg_v, seen.sum_v,
                        seen.over_v, seen.under_v, seen.low_v);
                  end
               end
            end
         end
      end
   end

   always @(negedge clock) begin : drive_reports
      board_report_type nxt;
      if (!reset && !(start && !req_taken)) begin
         if (reports_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt = reports_pending.pop_front();
            start <= 1'b1;
            req_board_index <= nxt.idx;
            req_board_min_voltage <= nxt.min_v;
            req_board_max_voltage <= nxt.max_v;
            req_board_avg_voltage <= nxt.avg_v;
         end else begin
            start <= 1'b0;
            req_board_index <= 3'($urandom);
            req_board_min_voltage <= 16'($urandom);
            req_board_max_voltage <= 16'($urandom);
            req_board_avg_voltage <= 16'($urandom);
         end
      end
   end

   function automatic void queue_report(int idx, int min_v, int max_v, int avg_v);
      reports_pending.push_back({3'(idx), 16'(min_v), 16'(max_v), 16'(avg_v)});
      reports_queued++;
   endfunction

   // mostly plausible reports around the limits, some raw noise and extremes
   function automatic void queue_random_reports(int count);
      int base;
      int lo;
      int hi;
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            base = $urandom_range(46000, 24000);
            lo = base - $urandom_range(4000, 0);
            hi = base + $urandom_range(4000, 0);
            queue_report($urandom_range(7), lo, hi, $urandom_range(hi, lo));
         end else if (kind < 90) begin
            queue_report($urandom, $urandom, $urandom, $urandom);
         end else begin
            queue_report($urandom_range(7), $urandom_range(1) ? 65535 : 0,
               $urandom_range(1) ? 65535 : 0, $urandom_range(1) ? 65535 : 0);
         end
      end
   endfunction

   task automatic write_limit(logic [cvpm_pkg::CSR_IDX_W-1:0] idx,
                              logic [cvpm_pkg::VOLT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(int ov, int uv, int lv);
      write_limit(cvpm_pkg::CSR_OV_LIMIT, 16'(ov));
      write_limit(cvpm_pkg::CSR_UV_LIMIT, 16'(uv));
      write_limit(cvpm_pkg::CSR_LV_WARN, 16'(lv));
      // writes to the spare index must leave all limits alone
      write_limit(CSR_UNUSED, 16'($urandom));
   endtask

   task automatic wait_drained();
      while (reports_taken != reports_queued || pack_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // field extremes on the end boards
      queue_report(0, 65535, 0, 0);
      queue_report(7, 0, 65535, 65535);
      queue_report(0, 0, 0, 0);
      queue_report(7, 65535, 65535, 0);
      // full tables for the largest pack sum, then everything cleared
      for (int b = 0; b < BOARDS; b++) begin
         queue_report(b, 65535, 65535, 65535);
      end
      for (int b = 0; b < BOARDS; b++) begin
         queue_report(b, 0, 0, 0);
      end
      // threshold edges of the default limits
      for (int b = 0; b < BOARDS; b++) begin
         queue_report(b, 35000, 40000, 37000);
      end
      queue_report(3, 28000, 42000, 35000);
      queue_report(3, 27999, 42001, 35000);
      queue_report(3, 29999, 41999, 35000);
      queue_report(3, 30000, 40000, 35000);
      queue_random_reports(PHASE_REPORTS);
      wait_drained();

      for (int phase = 1; phase < 6; phase++) begin
         sender_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 70 : 0;
         case (phase)
            1: set_limits(0, 0, 0);
            2: set_limits(65535, 65535, 65535);
            3: set_limits($urandom_range(48000, 38000), $urandom_range(30000, 22000),
                          $urandom_range(34000, 26000));
            4: set_limits(int'(cvpm_pkg::OV_LIMIT_RST), int'(cvpm_pkg::UV_LIMIT_RST),
                          int'(cvpm_pkg::LV_WARN_RST));
            default: set_limits($urandom, $urandom, $urandom);
         endcase
         queue_random_reports(PHASE_REPORTS);
         wait_drained();
      end

      $display("covered %0d board reports, %0d pack results checked", reports_queued,
         packs_checked);
      $display("%0d limit register transfers over six threshold settings", limit_writes);
      if (errors == 0 && pack_results_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule
